>>> hdl/tlmc_pkg.sv
// Shared types and codes for the two-lamp mode controller.
// No dependencies; used by tlmc_step and two_lamp_mode_controller.
package tlmc_pkg;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_NORMAL  = 2'd1,
    MODE_READING = 2'd2,
    MODE_NIGHT   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    DRV_NONE     = 3'd0,
    DRV_IMM      = 3'd1,
    DRV_FADE_IN  = 3'd2,
    DRV_FADE_OUT = 3'd3,
    DRV_MODE     = 3'd4,
    DRV_MODE_OFF = 3'd5,
    DRV_DOUBLE   = 3'd6
  } drive_t;

  typedef enum logic [1:0] {
    TMR_NONE  = 2'd0,
    TMR_START = 2'd1,
    TMR_STOP  = 2'd2
  } timer_t;

  localparam logic [1:0] FUNC_BUTTON  = 2'd0;
  localparam logic [1:0] FUNC_COMMAND = 2'd1;
  localparam logic [1:0] FUNC_NIGHT   = 2'd2;
  localparam logic [1:0] FUNC_TICK    = 2'd3;

  localparam logic [2:0] KEY_POWER   = 3'd0;
  localparam logic [2:0] KEY_UPPER   = 3'd1;
  localparam logic [2:0] KEY_LOWER   = 3'd2;
  localparam logic [2:0] KEY_READING = 3'd3;
  localparam logic [2:0] KEY_NIGHT   = 3'd4;

  localparam logic [1:0] PRESS_SHORT   = 2'd0;
  localparam logic [1:0] PRESS_LONG    = 2'd1;
  localparam logic [1:0] PRESS_RELEASE = 2'd2;
  localparam logic [1:0] PRESS_DOUBLE  = 2'd3;

  localparam logic [1:0] CMD_POWER  = 2'd0;
  localparam logic [1:0] CMD_SWITCH = 2'd1;
  localparam logic [1:0] CMD_LEVEL  = 2'd2;
  localparam logic [1:0] CMD_MODE   = 2'd3;

  localparam logic [7:0] SETMODE_NORMAL  = 8'd0;
  localparam logic [7:0] SETMODE_READING = 8'd1;
  localparam logic [7:0] SETMODE_NIGHT   = 8'd2;

  localparam logic [2:0] CFG_DIM_STEP    = 3'd0;
  localparam logic [2:0] CFG_MAX_LEVEL   = 3'd1;
  localparam logic [2:0] CFG_MIN_LEVEL   = 3'd2;
  localparam logic [2:0] CFG_NIGHT_LEVEL = 3'd3;
  localparam logic [2:0] CFG_START_UPPER = 3'd4;
  localparam logic [2:0] CFG_START_LOWER = 3'd5;

  localparam logic [6:0] LEVEL_CAP  = 7'd100;
  localparam logic [1:0] NO_TARGET  = 2'd2;

  typedef struct packed {
    logic [6:0] dim_step;
    logic [6:0] max_level;
    logic [6:0] min_level;
    logic [6:0] night_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] button;
    logic [1:0] press;
    logic [1:0] command;
    logic       lamp;
    logic [7:0] value;
  } item_t;

  // index 0 upper, 1 lower
  typedef struct packed {
    logic [1:0][6:0] br;
    logic [1:0]      sw;
  } view_t;

  typedef struct packed {
    mode_t           mode;
    logic [1:0]      sw;
    logic [1:0][6:0] br;
    view_t           saved;
    logic [1:0]      target;
    logic            rising;
  } state_t;

  typedef struct packed {
    drive_t [1:0] drv;
    logic [1:0]   save_lv;
    logic         save_sw;
    timer_t       ntimer;
    timer_t       dtimer;
    logic         note;
  } act_t;

  typedef struct packed {
    state_t st;
    act_t   act;
  } work_t;

endpackage

>>> hdl/tlmc_step.sv
// Next-state and action logic for one event of the two-lamp mode controller.
// Purely combinational; depends on tlmc_pkg.
module tlmc_step (
  input  tlmc_pkg::state_t st,
  input  tlmc_pkg::cfg_t   cfg,
  input  tlmc_pkg::item_t  item,
  output tlmc_pkg::state_t st_next,
  output tlmc_pkg::act_t   act
);
  import tlmc_pkg::*;

  function automatic work_t power_on(work_t w);
    work_t x;
    x = w;
    x.st.mode = MODE_NORMAL;
    x.st.sw = 2'b11;
    x.act.drv[0] = DRV_FADE_IN;
    x.act.drv[1] = DRV_FADE_IN;
    x.act.note = 1'b1;
    return x;
  endfunction

  function automatic work_t power_off(work_t w);
    work_t x;
    x = w;
    x.act.drv[0] = DRV_FADE_OUT;
    x.act.drv[1] = DRV_FADE_OUT;
    x.st.sw = 2'b00;
    x.st.mode = MODE_OFF;
    x.act.save_lv = 2'b11;
    x.act.save_sw = 1'b1;
    x.act.note = 1'b1;
    return x;
  endfunction

  function automatic work_t enter_reading(work_t w, logic [6:0] max_level);
    work_t x;
    x = w;
    x.st.saved.sw = x.st.sw;
    x.st.saved.br = x.st.br;
    x.st.sw = 2'b11;
    x.st.br[0] = max_level;
    x.st.br[1] = max_level;
    x.act.drv[0] = DRV_MODE;
    x.act.drv[1] = DRV_MODE;
    x.st.mode = MODE_READING;
    x.act.note = 1'b1;
    return x;
  endfunction

  function automatic work_t enter_night(work_t w, logic [6:0] night_level);
    work_t x;
    x = w;
    x.st.saved.sw = x.st.sw;
    x.st.saved.br = x.st.br;
    x.st.sw = 2'b01;
    x.st.br[0] = night_level;
    x.act.drv[0] = DRV_MODE;
    x.act.drv[1] = DRV_MODE_OFF;
    x.st.mode = MODE_NIGHT;
    x.act.ntimer = TMR_START;
    x.act.note = 1'b1;
    return x;
  endfunction

  function automatic work_t exit_special(work_t w);
    work_t x;
    x = w;
    if (x.st.mode == MODE_NIGHT) x.act.ntimer = TMR_STOP;
    x.st.sw = x.st.saved.sw;
    x.st.br = x.st.saved.br;
    x.act.drv[0] = x.st.sw[0] ? DRV_MODE : DRV_MODE_OFF;
    x.act.drv[1] = x.st.sw[1] ? DRV_MODE : DRV_MODE_OFF;
    x.st.mode = MODE_NORMAL;
    x.act.note = 1'b1;
    return x;
  endfunction

  function automatic work_t lamp_button(work_t w, logic l, logic [1:0] press, cfg_t c);
    work_t x;
    x = w;
    case (press)
      PRESS_SHORT: begin
        x.st.sw[l] = ~x.st.sw[l];
        x.act.drv[l] = x.st.sw[l] ? DRV_FADE_IN : DRV_FADE_OUT;
        x.act.note = 1'b1;
      end
      PRESS_LONG: begin
        if (x.st.sw[l]) begin
          x.st.target = {1'b0, l};
          x.st.rising = 1'b1;
          x.act.dtimer = TMR_START;
        end
      end
      PRESS_RELEASE: begin
        if (!x.st.target[1]) begin
          x.act.dtimer = TMR_STOP;
          x.act.save_lv[x.st.target[0]] = 1'b1;
          x.st.target = NO_TARGET;
          x.act.note = 1'b1;
        end
      end
      default: begin
        if (x.st.sw[l]) begin
          x.st.br[l] = (x.st.br[l] <= c.min_level) ? c.max_level : c.min_level;
          x.act.drv[l] = DRV_DOUBLE;
          x.act.save_lv[l] = 1'b1;
          x.act.note = 1'b1;
        end
      end
    endcase
    return x;
  endfunction

  function automatic work_t on_button(work_t w, item_t it, cfg_t c);
    work_t x;
    x = w;
    if (x.st.mode == MODE_READING) begin
      if (it.button != KEY_READING) begin
        x = exit_special(x);
        if (it.button == KEY_NIGHT && it.press == PRESS_SHORT) x = enter_night(x, c.night_level);
      end
    end else if (x.st.mode == MODE_NIGHT) begin
      if (it.button != KEY_NIGHT) begin
        x = exit_special(x);
        if (it.button == KEY_READING && it.press == PRESS_SHORT) x = enter_reading(x, c.max_level);
      end
    end else if (x.st.mode == MODE_OFF) begin
      if (it.button == KEY_POWER && it.press == PRESS_SHORT) x = power_on(x);
    end else begin
      case (it.button)
        KEY_POWER:   if (it.press == PRESS_SHORT) x = power_off(x);
        KEY_UPPER:   x = lamp_button(x, 1'b0, it.press, c);
        KEY_LOWER:   x = lamp_button(x, 1'b1, it.press, c);
        KEY_READING: if (it.press == PRESS_SHORT) x = enter_reading(x, c.max_level);
        KEY_NIGHT:   if (it.press == PRESS_SHORT) x = enter_night(x, c.night_level);
        default: ;
      endcase
    end
    return x;
  endfunction

  function automatic work_t on_command(work_t w, item_t it, cfg_t c);
    work_t x;
    x = w;
    case (it.command)
      CMD_POWER: begin
        if (x.st.mode == MODE_OFF) x = power_on(x);
        else x = power_off(x);
      end
      CMD_SWITCH: begin
        if (x.st.mode == MODE_OFF) x = power_on(x);
        if (x.st.mode == MODE_NORMAL) begin
          x.st.sw[it.lamp] = (it.value != 8'd0);
          x.act.drv[it.lamp] = x.st.sw[it.lamp] ? DRV_FADE_IN : DRV_FADE_OUT;
          x.act.note = 1'b1;
        end
      end
      CMD_LEVEL: begin
        if (x.st.mode == MODE_NORMAL) begin
          x.st.br[it.lamp] = (it.value > {1'b0, LEVEL_CAP}) ? LEVEL_CAP : it.value[6:0];
          if (x.st.sw[it.lamp]) x.act.drv[it.lamp] = DRV_MODE;
          x.act.save_lv[it.lamp] = 1'b1;
          x.act.note = 1'b1;
        end
      end
      default: begin
        if (x.st.mode != MODE_OFF) begin
          if (it.value == SETMODE_NORMAL) begin
            if (x.st.mode != MODE_NORMAL) x = exit_special(x);
          end else if (it.value == SETMODE_READING) begin
            if (x.st.mode != MODE_READING) begin
              if (x.st.mode != MODE_NORMAL) x = exit_special(x);
              x = enter_reading(x, c.max_level);
            end
          end else if (it.value == SETMODE_NIGHT) begin
            if (x.st.mode != MODE_NIGHT) begin
              if (x.st.mode != MODE_NORMAL) x = exit_special(x);
              x = enter_night(x, c.night_level);
            end
          end
        end
      end
    endcase
    return x;
  endfunction

  function automatic work_t on_dim_tick(work_t w, cfg_t c);
    work_t      x;
    logic       l;
    logic [7:0] sum;
    x = w;
    l = x.st.target[0];
    sum = {1'b0, x.st.br[l]} + {1'b0, c.dim_step};
    if (!x.st.target[1]) begin
      if (x.st.rising) begin
        if (sum >= {1'b0, c.max_level}) begin
          x.st.br[l] = c.max_level;
          x.st.rising = 1'b0;
        end else begin
          x.st.br[l] = sum[6:0];
        end
      end else if ({1'b0, x.st.br[l]} <= {1'b0, c.min_level} + {1'b0, c.dim_step}) begin
        x.st.br[l] = c.min_level;
        x.st.rising = 1'b1;
      end else begin
        x.st.br[l] = x.st.br[l] - c.dim_step;
      end
      x.act.drv[l] = DRV_IMM;
    end
    return x;
  endfunction

  function automatic work_t on_night_timeout(work_t w);
    work_t x;
    x = w;
    x.act.drv[0] = DRV_FADE_OUT;
    x.act.drv[1] = DRV_FADE_OUT;
    x.st.sw = 2'b00;
    x.st.mode = MODE_OFF;
    x.act.save_sw = 1'b1;
    x.act.note = 1'b1;
    return x;
  endfunction

  work_t w0;
  work_t w1;

  always_comb begin
    w0.st = st;
    w0.act.drv[0] = DRV_NONE;
    w0.act.drv[1] = DRV_NONE;
    w0.act.save_lv = 2'b00;
    w0.act.save_sw = 1'b0;
    w0.act.ntimer = TMR_NONE;
    w0.act.dtimer = TMR_NONE;
    w0.act.note = 1'b0;
    case (item.func)
      FUNC_BUTTON:  w1 = on_button(w0, item, cfg);
      FUNC_COMMAND: w1 = on_command(w0, item, cfg);
      FUNC_NIGHT:   w1 = on_night_timeout(w0);
      default:      w1 = on_dim_tick(w0, cfg);
    endcase
  end

  assign st_next = w1.st;
  assign act     = w1.act;

endmodule

>>> hdl/two_lamp_mode_controller.sv
// Top level of the two-lamp mode controller: channels, config registers, state.
// Depends on tlmc_pkg and tlmc_step.
//
// One event in, one status result out. An event is taken into an input register,
// applied to the lamp state from that register and its result is held in an output
// register until the consumer takes it. Throughput is one event per clock while the
// output is not stalled. The state update is one pass through
// tlmc_step, so back-to-back events see each other's effects. Start-level writes are
// accepted but reset reloads both levels to 100, so they never reach the lamps.
module two_lamp_mode_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [2:0] button,
  input  logic [1:0] press,
  input  logic [1:0] command,
  input  logic       lamp,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] mode,
  output logic       upper_on,
  output logic       lower_on,
  output logic [6:0] upper_level,
  output logic [6:0] lower_level,
  output logic [2:0] upper_drive,
  output logic [2:0] lower_drive,
  output logic [1:0] save_levels,
  output logic       save_switches_off,
  output logic [1:0] night_timer,
  output logic [1:0] dim_timer,
  output logic       notify,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data
);
  import tlmc_pkg::*;

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  act_t   act;
  item_t  item;
  logic   item_valid;
  logic   advance;
  state_t res_st;
  act_t   res_act;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_step    <= 7'd5;
      cfg.max_level   <= 7'd100;
      cfg.min_level   <= 7'd5;
      cfg.night_level <= 7'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIM_STEP:    cfg.dim_step    <= cfg_data;
        CFG_MAX_LEVEL:   cfg.max_level   <= cfg_data;
        CFG_MIN_LEVEL:   cfg.min_level   <= cfg_data;
        CFG_NIGHT_LEVEL: cfg.night_level <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.func    <= func;
      item.button  <= button;
      item.press   <= press;
      item.command <= command;
      item.lamp    <= lamp;
      item.value   <= value;
    end
  end

  tlmc_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (item),
    .st_next (st_next),
    .act     (act)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode   <= MODE_OFF;
      st.sw     <= 2'b00;
      st.br[0]  <= LEVEL_CAP;
      st.br[1]  <= LEVEL_CAP;
      st.saved  <= '0;
      st.target <= NO_TARGET;
      st.rising <= 1'b1;
    end else if (item_valid && advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      res_st  <= st_next;
      res_act <= act;
    end
  end

  assign mode              = res_st.mode;
  assign upper_on          = res_st.sw[0];
  assign lower_on          = res_st.sw[1];
  assign upper_level       = res_st.br[0];
  assign lower_level       = res_st.br[1];
  assign upper_drive       = res_act.drv[0];
  assign lower_drive       = res_act.drv[1];
  assign save_levels       = res_act.save_lv;
  assign save_switches_off = res_act.save_sw;
  assign night_timer       = res_act.ntimer;
  assign dim_timer         = res_act.dtimer;
  assign notify            = res_act.note;

endmodule

>>> dv/tb_two_lamp_mode_controller.sv
// Self-checking testbench for two_lamp_mode_controller: directed and random events
// under several register settings and handshake idle/stall mixes, with a built-in predictor.
// Depends on tlmc_pkg and the two_lamp_mode_controller RTL.
module tb_two_lamp_mode_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import tlmc_pkg::*;

  localparam logic [2:0] KEY_OTHER_LO    = 3'd5;
  localparam logic [2:0] KEY_OTHER_HI    = 3'd7;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    mode_t      mode;
    logic       upper_on;
    logic       lower_on;
    logic [6:0] upper_level;
    logic [6:0] lower_level;
    drive_t     upper_drive;
    drive_t     lower_drive;
    logic [1:0] save_levels;
    logic       save_switches_off;
    timer_t     night_timer;
    timer_t     dim_timer;
    logic       notify;
  } status_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func = '0;
  logic [2:0] button = '0;
  logic [1:0] press = '0;
  logic [1:0] command = '0;
  logic       lamp = 1'b0;
  logic [7:0] value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] mode;
  logic       upper_on;
  logic       lower_on;
  logic [6:0] upper_level;
  logic [6:0] lower_level;
  logic [2:0] upper_drive;
  logic [2:0] lower_drive;
  logic [1:0] save_levels;
  logic       save_switches_off;
  logic [1:0] night_timer;
  logic [1:0] dim_timer;
  logic       notify;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  two_lamp_mode_controller dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register copies
  logic [6:0] set_dim_step, set_max_level, set_min_level, set_night_level;
  logic [6:0] set_start_upper, set_start_lower;

  // lamp state, index 0 upper, 1 lower
  mode_t      lamp_mode;
  logic [1:0] lamp_on;
  logic [6:0] lamp_level [2];
  logic [1:0] snap_on;
  logic [6:0] snap_level [2];
  logic [1:0] sweep_lamp;
  logic       sweep_up;

  // per-request actions
  drive_t     act_drv [2];
  logic [1:0] act_save_lv;
  logic       act_save_sw;
  timer_t     act_ntimer;
  timer_t     act_dtimer;
  logic       act_note;

  item_t   pending_events [$];
  status_t expected_status [$];
  status_t want;
  item_t   seen_item;
  item_t   next_item;
  logic    req_taken = 1'b0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      error_count = 0;
  int      cycle_count = 0;

  function automatic void power_on();
    lamp_mode = MODE_NORMAL;
    lamp_on = 2'b11;
    act_drv[0] = DRV_FADE_IN;
    act_drv[1] = DRV_FADE_IN;
    act_note = 1'b1;
  endfunction

  function automatic void power_off();
    act_drv[0] = DRV_FADE_OUT;
    act_drv[1] = DRV_FADE_OUT;
    lamp_on = 2'b00;
    lamp_mode = MODE_OFF;
    act_save_lv = 2'b11;
    act_save_sw = 1'b1;
    act_note = 1'b1;
  endfunction

  function automatic void take_snapshot();
    snap_on = lamp_on;
    snap_level[0] = lamp_level[0];
    snap_level[1] = lamp_level[1];
  endfunction

  function automatic void enter_reading();
    take_snapshot();
    lamp_on = 2'b11;
    lamp_level[0] = set_max_level;
    lamp_level[1] = set_max_level;
    act_drv[0] = DRV_MODE;
    act_drv[1] = DRV_MODE;
    lamp_mode = MODE_READING;
    act_note = 1'b1;
  endfunction

  function automatic void enter_night();
    take_snapshot();
    lamp_on = 2'b01;
    lamp_level[0] = set_night_level;
    act_drv[0] = DRV_MODE;
    act_drv[1] = DRV_MODE_OFF;
    lamp_mode = MODE_NIGHT;
    act_ntimer = TMR_START;
    act_note = 1'b1;
  endfunction

  function automatic void leave_special();
    if (lamp_mode == MODE_NIGHT) act_ntimer = TMR_STOP;
    lamp_on = snap_on;
    lamp_level[0] = snap_level[0];
    lamp_level[1] = snap_level[1];
    act_drv[0] = lamp_on[0] ? DRV_MODE : DRV_MODE_OFF;
    act_drv[1] = lamp_on[1] ? DRV_MODE : DRV_MODE_OFF;
    lamp_mode = MODE_NORMAL;
    act_note = 1'b1;
  endfunction

  function automatic void lamp_press(logic l, logic [1:0] p);
    case (p)
      PRESS_SHORT: begin
        if (lamp_on[l]) begin
          lamp_on[l] = 1'b0;
          act_drv[l] = DRV_FADE_OUT;
        end else begin
          lamp_on[l] = 1'b1;
          act_drv[l] = DRV_FADE_IN;
        end
        act_note = 1'b1;
      end
      PRESS_LONG: begin
        if (lamp_on[l]) begin
          sweep_lamp = {1'b0, l};
          sweep_up = 1'b1;
          act_dtimer = TMR_START;
        end
      end
      PRESS_RELEASE: begin
        if (sweep_lamp < NO_TARGET) begin
          act_dtimer = TMR_STOP;
          act_save_lv[sweep_lamp[0]] = 1'b1;
          sweep_lamp = NO_TARGET;
          act_note = 1'b1;
        end
      end
      default: begin
        if (lamp_on[l]) begin
          lamp_level[l] = (lamp_level[l] <= set_min_level) ? set_max_level : set_min_level;
          act_drv[l] = DRV_DOUBLE;
          act_save_lv[l] = 1'b1;
          act_note = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic status_t predict_status(item_t ev);
    status_t s;
    int      sum;
    logic    t;
    act_drv[0] = DRV_NONE;
    act_drv[1] = DRV_NONE;
    act_save_lv = 2'b00;
    act_save_sw = 1'b0;
    act_ntimer = TMR_NONE;
    act_dtimer = TMR_NONE;
    act_note = 1'b0;
    case (ev.func)
      FUNC_BUTTON: begin
        if (lamp_mode == MODE_READING) begin
          if (ev.button != KEY_READING) begin
            leave_special();
            if (ev.button == KEY_NIGHT && ev.press == PRESS_SHORT) enter_night();
          end
        end else if (lamp_mode == MODE_NIGHT) begin
          if (ev.button != KEY_NIGHT) begin
            leave_special();
            if (ev.button == KEY_READING && ev.press == PRESS_SHORT) enter_reading();
          end
        end else if (lamp_mode == MODE_OFF) begin
          if (ev.button == KEY_POWER && ev.press == PRESS_SHORT) power_on();
        end else begin
          case (ev.button)
            KEY_POWER:   if (ev.press == PRESS_SHORT) power_off();
            KEY_UPPER:   lamp_press(1'b0, ev.press);
            KEY_LOWER:   lamp_press(1'b1, ev.press);
            KEY_READING: if (ev.press == PRESS_SHORT) enter_reading();
            KEY_NIGHT:   if (ev.press == PRESS_SHORT) enter_night();
            default: ;
          endcase
        end
      end
      FUNC_COMMAND: begin
        case (ev.command)
          CMD_POWER: begin
            if (lamp_mode == MODE_OFF) power_on();
            else power_off();
          end
          CMD_SWITCH: begin
            if (lamp_mode == MODE_OFF) power_on();
            if (lamp_mode == MODE_NORMAL) begin
              lamp_on[ev.lamp] = (ev.value != 8'd0);
              act_drv[ev.lamp] = lamp_on[ev.lamp] ? DRV_FADE_IN : DRV_FADE_OUT;
              act_note = 1'b1;
            end
          end
          CMD_LEVEL: begin
            if (lamp_mode == MODE_NORMAL) begin
              lamp_level[ev.lamp] = (ev.value > {1'b0, LEVEL_CAP}) ? LEVEL_CAP : ev.value[6:0];
              if (lamp_on[ev.lamp]) act_drv[ev.lamp] = DRV_MODE;
              act_save_lv[ev.lamp] = 1'b1;
              act_note = 1'b1;
            end
          end
          default: begin
            if (lamp_mode != MODE_OFF) begin
              if (ev.value == SETMODE_NORMAL) begin
                if (lamp_mode != MODE_NORMAL) leave_special();
              end else if (ev.value == SETMODE_READING) begin
                if (lamp_mode != MODE_READING) begin
                  if (lamp_mode != MODE_NORMAL) leave_special();
                  enter_reading();
                end
              end else if (ev.value == SETMODE_NIGHT) begin
                if (lamp_mode != MODE_NIGHT) begin
                  if (lamp_mode != MODE_NORMAL) leave_special();
                  enter_night();
                end
              end
            end
          end
        endcase
      end
      FUNC_NIGHT: begin
        act_drv[0] = DRV_FADE_OUT;
        act_drv[1] = DRV_FADE_OUT;
        lamp_on = 2'b00;
        lamp_mode = MODE_OFF;
        act_save_sw = 1'b1;
        act_note = 1'b1;
      end
      default: begin
        if (sweep_lamp < NO_TARGET) begin
          t = sweep_lamp[0];
          if (sweep_up) begin
            sum = int'(lamp_level[t]) + int'(set_dim_step);
            if (sum >= int'(set_max_level)) begin
              sum = int'(set_max_level);
              sweep_up = 1'b0;
            end
            lamp_level[t] = sum[6:0];
          end else begin
            // clamp at the minimum, never wrap
            if (int'(lamp_level[t]) <= int'(set_min_level) + int'(set_dim_step)) begin
              lamp_level[t] = set_min_level;
              sweep_up = 1'b1;
            end else begin
              lamp_level[t] = lamp_level[t] - set_dim_step;
            end
          end
          act_drv[t] = DRV_IMM;
        end
      end
    endcase
    s.mode = lamp_mode;
    s.upper_on = lamp_on[0];
    s.lower_on = lamp_on[1];
    s.upper_level = lamp_level[0];
    s.lower_level = lamp_level[1];
    s.upper_drive = act_drv[0];
    s.lower_drive = act_drv[1];
    s.save_levels = act_save_lv;
    s.save_switches_off = act_save_sw;
    s.night_timer = act_ntimer;
    s.dim_timer = act_dtimer;
    s.notify = act_note;
    return s;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      error_count++;
    end
  endfunction

  // predictor, scoreboard and request tracking
  always @(posedge clk) begin
    if (rst) begin
      set_dim_step = 7'd5;
      set_max_level = 7'd100;
      set_min_level = 7'd5;
      set_night_level = 7'd5;
      set_start_upper = 7'd100;
      set_start_lower = 7'd100;
      lamp_mode = MODE_OFF;
      lamp_on = 2'b00;
      lamp_level[0] = set_start_upper;
      lamp_level[1] = set_start_lower;
      snap_on = 2'b00;
      snap_level[0] = 7'd0;
      snap_level[1] = 7'd0;
      sweep_lamp = NO_TARGET;
      sweep_up = 1'b1;
      expected_status.delete();
      req_taken = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIM_STEP:    set_dim_step = cfg_data;
          CFG_MAX_LEVEL:   set_max_level = cfg_data;
          CFG_MIN_LEVEL:   set_min_level = cfg_data;
          CFG_NIGHT_LEVEL: set_night_level = cfg_data;
          CFG_START_UPPER: set_start_upper = cfg_data;
          CFG_START_LOWER: set_start_lower = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("status result with no request pending");
          error_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("mode", 8'(want.mode), 8'(mode));
          check_field("upper_on", 8'(want.upper_on), 8'(upper_on));
          check_field("lower_on", 8'(want.lower_on), 8'(lower_on));
          check_field("upper_level", 8'(want.upper_level), 8'(upper_level));
          check_field("lower_level", 8'(want.lower_level), 8'(lower_level));
          check_field("upper_drive", 8'(want.upper_drive), 8'(upper_drive));
          check_field("lower_drive", 8'(want.lower_drive), 8'(lower_drive));
          check_field("save_levels", 8'(want.save_levels), 8'(save_levels));
          check_field("save_switches_off", 8'(want.save_switches_off),
                      8'(save_switches_off));
          check_field("night_timer", 8'(want.night_timer), 8'(night_timer));
          check_field("dim_timer", 8'(want.dim_timer), 8'(dim_timer));
          check_field("notify", 8'(want.notify), 8'(notify));
        end
      end
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        seen_item = '{func, button, press, command, lamp, value};
        expected_status.push_back(predict_status(seen_item));
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_item = pending_events.pop_front();
        in_valid <= 1'b1;
        func <= next_item.func;
        button <= next_item.button;
        press <= next_item.press;
        command <= next_item.command;
        lamp <= next_item.lamp;
        value <= next_item.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic item_t random_item();
    item_t it;
    it.func = 2'($urandom_range(0, 3));
    it.button = 3'($urandom_range(0, 7));
    it.press = 2'($urandom_range(0, 3));
    it.command = 2'($urandom_range(0, 3));
    it.lamp = 1'($urandom_range(0, 1));
    it.value = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic void add_button(logic [2:0] b, logic [1:0] p);
    item_t it;
    it = random_item();
    it.func = FUNC_BUTTON;
    it.button = b;
    it.press = p;
    pending_events.push_back(it);
  endfunction

  function automatic void add_command(logic [1:0] c, logic l, logic [7:0] v);
    item_t it;
    it = random_item();
    it.func = FUNC_COMMAND;
    it.command = c;
    it.lamp = l;
    it.value = v;
    pending_events.push_back(it);
  endfunction

  function automatic void add_event(logic [1:0] f);
    item_t it;
    it = random_item();
    it.func = f;
    pending_events.push_back(it);
  endfunction

  function automatic void add_random_events(int count);
    int   pick;
    int   n;
    logic l;
    while (pending_events.size() < count) begin
      pick = int'($urandom_range(0, 99));
      l = 1'($urandom_range(0, 1));
      if (pick < 30) begin
        // full sweep: normal, lamp on, hold, tick, release or double-press on other lamp
        if ($urandom_range(0, 1) != 0) add_command(CMD_MODE, l, SETMODE_NORMAL);
        if ($urandom_range(0, 3) != 0) add_command(CMD_SWITCH, l, 8'($urandom_range(1, 255)));
        add_button(l ? KEY_LOWER : KEY_UPPER, PRESS_LONG);
        n = int'($urandom_range(1, 25));
        repeat (n) add_event(FUNC_TICK);
        add_button(l ? KEY_UPPER : KEY_LOWER, $urandom_range(0, 3) != 0 ? PRESS_RELEASE
                                                                      : PRESS_DOUBLE);
      end else if (pick < 45) begin
        add_button(l ? KEY_READING : KEY_NIGHT, PRESS_SHORT);
        pending_events.push_back(random_item());
      end else if (pick < 65) begin
        add_command(2'($urandom_range(0, 3)), l,
                    8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 4)));
      end else if (pick < 85) begin
        add_button(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      end else if (pick < 90) begin
        add_event(FUNC_NIGHT);
      end else begin
        pending_events.push_back(random_item());
      end
    end
  endfunction

  task automatic write_setting(logic [2:0] idx, logic [6:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(logic [6:0] d, logic [6:0] mx, logic [6:0] mn,
                                logic [6:0] nt, logic [6:0] su, logic [6:0] sl);
    write_setting(CFG_DIM_STEP, d);
    write_setting(CFG_MAX_LEVEL, mx);
    write_setting(CFG_MIN_LEVEL, mn);
    write_setting(CFG_NIGHT_LEVEL, nt);
    write_setting(CFG_START_UPPER, su);
    write_setting(CFG_START_LOWER, sl);
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pass on reset settings
    add_button(KEY_POWER, PRESS_LONG);
    add_event(FUNC_TICK);
    add_button(KEY_POWER, PRESS_SHORT);
    add_button(KEY_UPPER, PRESS_DOUBLE);
    add_button(KEY_UPPER, PRESS_DOUBLE);
    add_command(CMD_LEVEL, 1'b0, 8'd98);
    add_button(KEY_UPPER, PRESS_LONG);
    add_event(FUNC_TICK);
    add_command(CMD_LEVEL, 1'b0, 8'd3);
    add_event(FUNC_TICK);
    add_button(KEY_LOWER, PRESS_RELEASE);
    add_command(CMD_LEVEL, 1'b1, 8'd255);
    add_button(KEY_OTHER_LO, PRESS_SHORT);
    add_button(KEY_READING, PRESS_SHORT);
    add_button(KEY_READING, PRESS_LONG);
    add_button(KEY_OTHER_HI, PRESS_RELEASE);
    add_button(KEY_NIGHT, PRESS_SHORT);
    add_button(KEY_READING, PRESS_SHORT);
    add_button(KEY_NIGHT, PRESS_SHORT);
    add_command(CMD_MODE, 1'b0, 8'($urandom_range(SETMODE_NIGHT + 8'd1, 255)));
    add_command(CMD_POWER, 1'b1, 8'd0);
    add_command(CMD_MODE, 1'b0, SETMODE_READING);
    add_command(CMD_SWITCH, 1'b1, 8'd0);
    add_command(CMD_MODE, 1'b1, SETMODE_NIGHT);
    add_event(FUNC_NIGHT);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_settings(7'd5, 7'd100, 7'd5, 7'd5, 7'd100, 7'd100);
        1: apply_settings(7'd1, 7'd100, 7'd0, 7'd0, 7'd0, 7'd0);
        2: apply_settings(7'd100, 7'd1, 7'd100, 7'd100, 7'd100, 7'd100);
        3: apply_settings(7'd7, 7'd90, 7'd10, 7'd30, 7'd55, 7'd20);
        4: apply_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                          7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                          7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        default: apply_settings(7'($urandom_range(1, 100)), 7'($urandom_range(1, 100)),
                                7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)),
                                7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)));
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      add_random_events(100);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
